// File: hw/rtl/irpwcd_pkg.sv
// Package for the IR pulse-width code decoder.
// Holds the phase type, result and request types, register indexes and constants.
// No dependencies.
package irpwcd_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 8;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_HDR_PULSE_PRELOAD = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_HDR_PULSE_MIN     = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_HDR_GAP_PRELOAD   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_HDR_GAP_MIN       = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_SHORT_PRELOAD     = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_SHORT_MIN         = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_LONG_PRELOAD      = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_LONG_MIN          = 3'd7;

  // register reset values
  localparam logic [7:0] RST_HDR_PULSE_PRELOAD = 8'd176;
  localparam logic [7:0] RST_HDR_PULSE_MIN     = 8'd226;
  localparam logic [7:0] RST_HDR_GAP_PRELOAD   = 8'd206;
  localparam logic [7:0] RST_HDR_GAP_MIN       = 8'd236;
  localparam logic [7:0] RST_SHORT_PRELOAD     = 8'd242;
  localparam logic [7:0] RST_SHORT_MIN         = 8'd247;
  localparam logic [7:0] RST_LONG_PRELOAD      = 8'd222;
  localparam logic [7:0] RST_LONG_MIN          = 8'd227;

  // gap readings above this are a 1
  localparam logic [7:0] BIT_ONE_THRESHOLD = 8'd240;
  // fine timebase correction subtracted from the raw byte
  localparam logic [7:0] FRACTION_ADJUST = 8'h0B;

  // event kinds
  localparam logic FUNC_EDGE     = 1'b0;
  localparam logic FUNC_OVERFLOW = 1'b1;

  // phase: which interval the next edge closes
  typedef enum logic [2:0] {
    PH_SEARCH     = 3'd0,
    PH_HDR_PULSE  = 3'd1,
    PH_HDR_GAP    = 3'd2,
    PH_BIT0_PULSE = 3'd3,
    PH_BIT0_GAP   = 3'd4,
    PH_BIT1_PULSE = 3'd5,
    PH_BIT1_GAP   = 3'd6,
    PH_TRAILER    = 3'd7
  } phase_t;

  typedef struct packed {
    logic        code_valid;
    logic [1:0]  code;
    logic [15:0] hit_ticks;
    logic [7:0]  hit_fraction;
    logic [7:0]  timer_preload;
    logic        timer_run;
  } result_t;

  typedef struct packed {
    logic        func;
    logic        pin_level;
    logic [7:0]  timer_reading;
    logic [15:0] now_ticks;
    logic [7:0]  now_fraction_raw;
  } request_t;

endpackage

// File: hw/rtl/ir_pulse_width_code_decoder.sv
// Top level of the IR pulse-width code decoder.
// Input register, phase logic and result register in one module.
// Depends on irpwcd_pkg.

// The decoder follows a beacon frame (header pulse, header gap, two data bits
// each made of a short pulse and a gap, trailer pulse) one request at a time.
// A request is either a pin edge with the interval timer reading taken at that
// edge, or a timer overflow. Every request yields exactly one result: the
// preload for the interval timer and whether it should run, plus, on the edge
// that closes the trailer, the 2-bit code (first bit in the MSB) and a hit
// time stamp. Throughput is one request per clock while out_stall is low;
// a request passes the input register, the phase logic, then the result
// register. Phase, window and bit registers update as a request leaves the input
// register, so one directly behind sees the new phase. The user must write
// configuration via cfg_* only with no request in flight; block does not enforce.
module ir_pulse_width_code_decoder (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_wdata,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_func,
  input  logic        in_pin_level,
  input  logic [7:0]  in_timer_reading,
  input  logic [15:0] in_now_ticks,
  input  logic [7:0]  in_now_fraction_raw,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_code_valid,
  output logic [1:0]  out_code,
  output logic [15:0] out_hit_ticks,
  output logic [7:0]  out_hit_fraction,
  output logic [7:0]  out_timer_preload,
  output logic        out_timer_run
);

  // configuration registers
  logic [7:0] hdr_pulse_preload_r, hdr_pulse_min_r;
  logic [7:0] hdr_gap_preload_r, hdr_gap_min_r;
  logic [7:0] short_preload_r, short_min_r;
  logic [7:0] long_preload_r, long_min_r;

  // frame state
  irpwcd_pkg::phase_t phase_r, phase_nxt;
  logic [7:0] win_min_r, win_min_nxt;
  logic [7:0] win_preload_r, win_preload_nxt;
  logic [1:0] bits_r, bits_nxt;

  // pipeline
  logic                   s1_valid_r;
  irpwcd_pkg::request_t   s1_req_r;
  logic                   out_valid_r;
  irpwcd_pkg::result_t    res_r, res_nxt;

  logic out_free;
  logic s1_fire;
  logic in_fire;
  logic search;
  logic bit_val;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_fire  = s1_valid_r && out_free;
  // input register frees when it moves on to the result register
  assign in_stall = s1_valid_r && !out_free;
  assign in_fire  = in_valid && !in_stall;

  // --------------------------------------------------------------------
  // configuration writes
  // --------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_pulse_preload_r <= irpwcd_pkg::RST_HDR_PULSE_PRELOAD;
      hdr_pulse_min_r     <= irpwcd_pkg::RST_HDR_PULSE_MIN;
      hdr_gap_preload_r   <= irpwcd_pkg::RST_HDR_GAP_PRELOAD;
      hdr_gap_min_r       <= irpwcd_pkg::RST_HDR_GAP_MIN;
      short_preload_r     <= irpwcd_pkg::RST_SHORT_PRELOAD;
      short_min_r         <= irpwcd_pkg::RST_SHORT_MIN;
      long_preload_r      <= irpwcd_pkg::RST_LONG_PRELOAD;
      long_min_r          <= irpwcd_pkg::RST_LONG_MIN;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        irpwcd_pkg::CFG_HDR_PULSE_PRELOAD: hdr_pulse_preload_r <= cfg_wdata;
        irpwcd_pkg::CFG_HDR_PULSE_MIN:     hdr_pulse_min_r     <= cfg_wdata;
        irpwcd_pkg::CFG_HDR_GAP_PRELOAD:   hdr_gap_preload_r   <= cfg_wdata;
        irpwcd_pkg::CFG_HDR_GAP_MIN:       hdr_gap_min_r       <= cfg_wdata;
        irpwcd_pkg::CFG_SHORT_PRELOAD:     short_preload_r     <= cfg_wdata;
        irpwcd_pkg::CFG_SHORT_MIN:         short_min_r         <= cfg_wdata;
        irpwcd_pkg::CFG_LONG_PRELOAD:      long_preload_r      <= cfg_wdata;
        irpwcd_pkg::CFG_LONG_MIN:          long_min_r          <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------
  // input register
  // --------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_req_r.func             <= in_func;
      s1_req_r.pin_level        <= in_pin_level;
      s1_req_r.timer_reading    <= in_timer_reading;
      s1_req_r.now_ticks        <= in_now_ticks;
      s1_req_r.now_fraction_raw <= in_now_fraction_raw;
    end
  end

  // --------------------------------------------------------------------
  // phase logic
  // --------------------------------------------------------------------
  // a short reading, or no frame in progress, restarts header search
  assign search  = (s1_req_r.timer_reading < win_min_r) ||
                   (phase_r == irpwcd_pkg::PH_SEARCH);
  // long gap is a 1
  assign bit_val = s1_req_r.timer_reading > irpwcd_pkg::BIT_ONE_THRESHOLD;

  always_comb begin
    phase_nxt       = phase_r;
    win_min_nxt     = win_min_r;
    win_preload_nxt = win_preload_r;
    bits_nxt        = bits_r;
    res_nxt         = '0;

    if (s1_req_r.func == irpwcd_pkg::FUNC_OVERFLOW) begin
      // timeout: drop the frame, stop the timer, keep windows and bits
      phase_nxt = irpwcd_pkg::PH_SEARCH;
    end else if (!search) begin
      unique case (phase_r)
        irpwcd_pkg::PH_HDR_PULSE: begin
          win_preload_nxt = hdr_gap_preload_r;
          win_min_nxt     = hdr_gap_min_r;
        end
        irpwcd_pkg::PH_HDR_GAP: begin
          win_preload_nxt = short_preload_r;
          win_min_nxt     = short_min_r;
        end
        irpwcd_pkg::PH_BIT0_PULSE,
        irpwcd_pkg::PH_BIT1_PULSE: begin
          win_preload_nxt = long_preload_r;
          win_min_nxt     = long_min_r;
        end
        irpwcd_pkg::PH_BIT0_GAP,
        irpwcd_pkg::PH_BIT1_GAP: begin
          bits_nxt        = {bits_r[0], bit_val};
          win_preload_nxt = short_preload_r;
          win_min_nxt     = short_min_r;
        end
        irpwcd_pkg::PH_TRAILER,
        irpwcd_pkg::PH_SEARCH: begin
          // frame complete (search phase cannot reach here)
          win_preload_nxt      = '0;
          win_min_nxt          = '0;
          res_nxt.code_valid   = 1'b1;
          res_nxt.code         = bits_r;
          res_nxt.hit_ticks    = s1_req_r.now_ticks;
          res_nxt.hit_fraction = s1_req_r.now_fraction_raw - irpwcd_pkg::FRACTION_ADJUST;
        end
        default: ;
      endcase
      if (phase_r == irpwcd_pkg::PH_TRAILER) begin
        phase_nxt = irpwcd_pkg::PH_SEARCH;
      end else begin
        phase_nxt             = irpwcd_pkg::phase_t'(phase_r + 3'd1);
        res_nxt.timer_preload = win_preload_nxt;
        res_nxt.timer_run     = 1'b1;
      end
    end else begin
      bits_nxt = '0;
      if (!s1_req_r.pin_level) begin
        // falling edge: possible header pulse
        win_preload_nxt       = hdr_pulse_preload_r;
        win_min_nxt           = hdr_pulse_min_r;
        phase_nxt             = irpwcd_pkg::PH_HDR_PULSE;
        res_nxt.timer_preload = hdr_pulse_preload_r;
        res_nxt.timer_run     = 1'b1;
      end else begin
        win_preload_nxt = '0;
        win_min_nxt     = '0;
        phase_nxt       = irpwcd_pkg::PH_SEARCH;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= irpwcd_pkg::PH_SEARCH;
      win_min_r     <= '0;
      win_preload_r <= '0;
      bits_r        <= '0;
    end else if (s1_fire) begin
      phase_r       <= phase_nxt;
      win_min_r     <= win_min_nxt;
      win_preload_r <= win_preload_nxt;
      bits_r        <= bits_nxt;
    end
  end

  // --------------------------------------------------------------------
  // result register
  // --------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_code_valid    = res_r.code_valid;
  assign out_code          = res_r.code;
  assign out_hit_ticks     = res_r.hit_ticks;
  assign out_hit_fraction  = res_r.hit_fraction;
  assign out_timer_preload = res_r.timer_preload;
  assign out_timer_run     = res_r.timer_run;

  // --------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------
  // a completed frame always stops the timer
  a_frame_stops_timer: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.code_valid) |-> (!res_r.timer_run && res_r.timer_preload == 8'd0))
    else $error("completed frame left the timer running");

  // a stopped timer carries no preload
  a_stop_no_preload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !res_r.timer_run) |-> (res_r.timer_preload == 8'd0))
    else $error("preload given with timer stopped");

  // a timeout always drops back to header search
  a_overflow_search: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_req_r.func == irpwcd_pkg::FUNC_OVERFLOW) |=>
      (phase_r == irpwcd_pkg::PH_SEARCH))
    else $error("timeout did not restart search");

  // the request side only stalls with the input register full
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r))
    else $error("request stalled with room to take it");

endmodule
